[hdl/modbus_rtu_response_framer_unit_defines.svh]
// Assertion macros for the Modbus RTU response framer checker.
// Depends on nothing; included by the checker file only.
`ifndef MODBUS_RTU_RESPONSE_FRAMER_UNIT_DEFINES_SVH
`define MODBUS_RTU_RESPONSE_FRAMER_UNIT_DEFINES_SVH

// same-cycle implication, reset masked
`define MRF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mrf port check failed");

// next-cycle implication, reset masked
`define MRF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mrf port check failed");

`endif

[hdl/mrf_pkg.sv]
// Shared types, codes and the CRC-16 byte update for the response framer.
// No dependencies.
package mrf_pkg;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_ADDR  = 3'd1;
    localparam logic [2:0] PH_FUNC  = 3'd2;
    localparam logic [2:0] PH_COUNT = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_CRC1  = 3'd5;
    localparam logic [2:0] PH_CRC2  = 3'd6;
    localparam logic [2:0] PH_END   = 3'd7;

    localparam logic [2:0] ROLE_ADDR    = 3'd0;
    localparam logic [2:0] ROLE_FUNC    = 3'd1;
    localparam logic [2:0] ROLE_COUNT   = 3'd2;
    localparam logic [2:0] ROLE_DATA    = 3'd3;
    localparam logic [2:0] ROLE_CRC1    = 3'd4;
    localparam logic [2:0] ROLE_CRC2    = 3'd5;
    localparam logic [2:0] ROLE_IGNORED = 3'd6;

    localparam logic [1:0] ACT_START   = 2'd0;
    localparam logic [1:0] ACT_BYTE    = 2'd1;
    localparam logic [1:0] ACT_RELEASE = 2'd2;

    localparam logic [1:0] CRC_HOLD    = 2'd0;
    localparam logic [1:0] CRC_RESTART = 2'd1;
    localparam logic [1:0] CRC_PUSH    = 2'd2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef struct packed {
        logic [2:0]  frame_state;
        logic [2:0]  byte_role;
        logic [7:0]  byte_value;
        logic [7:0]  data_index;
        logic        address_mismatch;
        logic        frame_done;
        logic [1:0]  crc_op;
        logic [7:0]  first_crc;
    } mrf_word_t;

    function automatic logic [15:0] crc_push(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[hdl/mrf_front.sv]
// Front end: accepts words, tracks the frame phase and classifies each byte.
// Depends on mrf_pkg.
module mrf_front
    import mrf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        accept,
    input  logic [1:0]  action,
    input  logic [7:0]  rx_byte,
    output mrf_word_t   word
);

    logic [7:0] expected_address_reg;
    logic [2:0] frame_phase_reg, frame_phase_next;
    logic [7:0] payload_length_reg, payload_length_next;
    logic [7:0] payload_taken_reg, payload_taken_next;
    logic [7:0] first_crc_byte_reg, first_crc_byte_next;
    logic [7:0] taken_inc;

    assign taken_inc = payload_taken_reg + 8'd1;

    always_comb
    begin
        frame_phase_next    = frame_phase_reg;
        payload_length_next = payload_length_reg;
        payload_taken_next  = payload_taken_reg;
        first_crc_byte_next = first_crc_byte_reg;
        word                = '0;
        word.byte_role      = ROLE_IGNORED;
        word.crc_op         = CRC_HOLD;
        unique case (action)
            ACT_START:   frame_phase_next = PH_ADDR;
            ACT_RELEASE: frame_phase_next = PH_IDLE;
            ACT_BYTE:
            begin
                word.byte_value = rx_byte;
                unique case (frame_phase_reg)
                    PH_ADDR:
                    begin
                        word.byte_role     = ROLE_ADDR;
                        word.crc_op        = CRC_RESTART;
                        payload_taken_next = 8'd0;
                        if (rx_byte != expected_address_reg)
                        begin
                            word.address_mismatch = 1'b1;
                            frame_phase_next      = PH_END;
                        end
                        else
                        begin
                            frame_phase_next = PH_FUNC;
                        end
                    end
                    PH_FUNC:
                    begin
                        word.byte_role   = ROLE_FUNC;
                        word.crc_op      = CRC_PUSH;
                        frame_phase_next = PH_COUNT;
                    end
                    PH_COUNT:
                    begin
                        word.byte_role      = ROLE_COUNT;
                        word.crc_op         = CRC_PUSH;
                        payload_length_next = rx_byte;
                        frame_phase_next    = (rx_byte == 8'd0) ? PH_CRC1 : PH_DATA;
                    end
                    PH_DATA:
                    begin
                        word.byte_role     = ROLE_DATA;
                        word.crc_op        = CRC_PUSH;
                        word.data_index    = payload_taken_reg;
                        payload_taken_next = taken_inc;
                        if (taken_inc >= payload_length_reg)
                        begin
                            frame_phase_next = PH_CRC1;
                        end
                    end
                    PH_CRC1:
                    begin
                        word.byte_role      = ROLE_CRC1;
                        first_crc_byte_next = rx_byte;
                        frame_phase_next    = PH_CRC2;
                    end
                    PH_CRC2:
                    begin
                        word.byte_role   = ROLE_CRC2;
                        word.frame_done  = 1'b1;
                        frame_phase_next = PH_END;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        word.first_crc   = first_crc_byte_reg;
        word.frame_state = frame_phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_address_reg <= 8'd0;
            frame_phase_reg      <= PH_IDLE;
            payload_length_reg   <= 8'd0;
            payload_taken_reg    <= 8'd0;
            first_crc_byte_reg   <= 8'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                expected_address_reg <= cfg_wdata;
            end
            if (accept)
            begin
                frame_phase_reg    <= frame_phase_next;
                payload_length_reg <= payload_length_next;
                payload_taken_reg  <= payload_taken_next;
                first_crc_byte_reg <= first_crc_byte_next;
            end
        end
    end

endmodule

[hdl/mrf_queue.sv]
// Two-entry queue of classified words between front and back.
// Depends on mrf_pkg.
module mrf_queue
    import mrf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  mrf_word_t push_word,
    input  logic      pop,
    output logic      full,
    output logic      not_empty,
    output mrf_word_t head
);

    mrf_word_t  store [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = store[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

[hdl/mrf_back.sv]
// Back end: runs the CRC-16, checks the received CRC and holds the output word.
// Depends on mrf_pkg.
module mrf_back
    import mrf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  mrf_word_t   head,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  frame_state,
    output logic [2:0]  byte_role,
    output logic [7:0]  byte_value,
    output logic [7:0]  data_index,
    output logic        address_mismatch,
    output logic [15:0] running_crc,
    output logic        frame_done,
    output logic        crc_match
);

    logic [15:0] crc_reg, crc_next;
    logic        out_valid_reg;
    logic        match;

    always_comb
    begin
        case (head.crc_op)
            CRC_RESTART: crc_next = crc_push(CRC_INIT, head.byte_value);
            CRC_PUSH:    crc_next = crc_push(crc_reg, head.byte_value);
            default:     crc_next = crc_reg;
        endcase
    end

    assign match     = head.frame_done && ({head.byte_value, head.first_crc} == crc_reg);
    assign pop       = q_valid && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                crc_reg       <= crc_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            frame_state      <= head.frame_state;
            byte_role        <= head.byte_role;
            byte_value       <= head.byte_value;
            data_index       <= head.data_index;
            address_mismatch <= head.address_mismatch;
            running_crc      <= crc_next;
            frame_done       <= head.frame_done;
            crc_match        <= match;
        end
    end

endmodule

[hdl/modbus_rtu_response_framer_unit.sv]
// Top level of the Modbus RTU response framer: front, queue and back.
// Depends on mrf_pkg, mrf_front, mrf_queue, mrf_back.
//
// channel  handshake             payload
// in       in_valid / in_stall   action, rx_byte
// out      out_valid / out_stall frame_state .. crc_match
// cfg      cfg_we                cfg_wdata (expected address)
//
// One word per cycle sustained while out_stall is low; an accepted word passes
// the queue, then the back's output register, where it shows with out_valid high.
// The front updates the frame phase in the accept cycle; the back runs the
// byte-wide CRC update into the output register. rst_n clears phase, CRC
// (to 0xFFFF), address and queue. in_stall rises only when the two-entry
// queue is full behind a stalled output word.
module modbus_rtu_response_framer_unit
    import mrf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  frame_state,
    output logic [2:0]  byte_role,
    output logic [7:0]  byte_value,
    output logic [7:0]  data_index,
    output logic        address_mismatch,
    output logic [15:0] running_crc,
    output logic        frame_done,
    output logic        crc_match
);

    mrf_word_t front_word;
    mrf_word_t head_word;
    logic      accept;
    logic      q_full;
    logic      q_valid;
    logic      pop;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    mrf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .action    (action),
        .rx_byte   (rx_byte),
        .word      (front_word)
    );

    mrf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_word (front_word),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head      (head_word)
    );

    mrf_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (q_valid),
        .head             (head_word),
        .pop              (pop),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .frame_state      (frame_state),
        .byte_role        (byte_role),
        .byte_value       (byte_value),
        .data_index       (data_index),
        .address_mismatch (address_mismatch),
        .running_crc      (running_crc),
        .frame_done       (frame_done),
        .crc_match        (crc_match)
    );

endmodule

[hdl/mrf_checker.sv]
// Port-level checks for the response framer, bound to the top level.
// Depends on mrf_pkg and modbus_rtu_response_framer_unit_defines.svh.
`include "modbus_rtu_response_framer_unit_defines.svh"

module mrf_checker
    import mrf_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  frame_state,
    input logic [2:0]  byte_role,
    input logic [7:0]  byte_value,
    input logic        address_mismatch,
    input logic [15:0] running_crc,
    input logic        frame_done,
    input logic        crc_match
);

    `MRF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(running_crc) && $stable(frame_state) && $stable(byte_value))
    `MRF_ASSERT_NOW(a_done_end, clk, rst_n, out_valid && frame_done,
        frame_state == PH_END && byte_role == ROLE_CRC2)
    `MRF_ASSERT_NOW(a_mismatch, clk, rst_n, out_valid && address_mismatch,
        frame_state == PH_END && byte_role == ROLE_ADDR)
    `MRF_ASSERT_NOW(a_match_gate, clk, rst_n, out_valid && !frame_done, !crc_match)

endmodule

bind modbus_rtu_response_framer_unit mrf_checker u_mrf_checker (.*);

[verif/tb_modbus_rtu_response_framer_unit.sv]
`timescale 1ns / 1ps
// Self-checking testbench for modbus_rtu_response_framer_unit: directed and random frames.
// Depends on mrf_pkg and the framer RTL; a local frame tracker predicts every output word.
module tb_modbus_rtu_response_framer_unit;
    import mrf_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int RAND_WORDS = 900;

    typedef struct packed {
        logic [2:0]  frame_state;
        logic [2:0]  byte_role;
        logic [7:0]  byte_value;
        logic [7:0]  data_index;
        logic        address_mismatch;
        logic [15:0] running_crc;
        logic        frame_done;
        logic        crc_match;
    } frame_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_wdata = 8'h00;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  action = ACT_START;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  frame_state;
    logic [2:0]  byte_role;
    logic [7:0]  byte_value;
    logic [7:0]  data_index;
    logic        address_mismatch;
    logic [15:0] running_crc;
    logic        frame_done;
    logic        crc_match;

    // frame tracker state
    logic [2:0]  trk_phase = PH_IDLE;
    logic [15:0] trk_crc = CRC_INIT;
    logic [7:0]  trk_len = 8'h00;
    logic [7:0]  trk_taken = 8'h00;
    logic [7:0]  trk_first = 8'h00;
    logic [7:0]  trk_addr = 8'h00;

    frame_word_t pending_words[$];
    frame_word_t want_word;
    int          mismatches = 0;
    int          words_sent = 0;
    bit          quiet = 1'b0;

    modbus_rtu_response_framer_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .action           (action),
        .rx_byte          (rx_byte),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .frame_state      (frame_state),
        .byte_role        (byte_role),
        .byte_value       (byte_value),
        .data_index       (data_index),
        .address_mismatch (address_mismatch),
        .running_crc      (running_crc),
        .frame_done       (frame_done),
        .crc_match        (crc_match)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [15:0] crc16_modbus_byte(input logic [15:0] acc,
                                                      input logic [7:0] b);
        logic [15:0] r;
        r = acc ^ {8'h00, b};
        repeat (8)
            r = {1'b0, r[15:1]} ^ (r[0] ? CRC_POLY : 16'h0000);
        return r;
    endfunction

    function automatic frame_word_t next_frame_word(input logic [1:0] act, input logic [7:0] b);
        frame_word_t w;
        w = '0;
        w.byte_role = ROLE_IGNORED;
        case (act)
            ACT_START:   trk_phase = PH_ADDR;
            ACT_RELEASE: trk_phase = PH_IDLE;
            ACT_BYTE:
            begin
                w.byte_value = b;
                case (trk_phase)
                    PH_ADDR:
                    begin
                        w.byte_role = ROLE_ADDR;
                        trk_taken = 8'h00;
                        trk_crc = crc16_modbus_byte(CRC_INIT, b);
                        if (b != trk_addr)
                        begin
                            w.address_mismatch = 1'b1;
                            trk_phase = PH_END;
                        end
                        else
                            trk_phase = PH_FUNC;
                    end
                    PH_FUNC:
                    begin
                        w.byte_role = ROLE_FUNC;
                        trk_crc = crc16_modbus_byte(trk_crc, b);
                        trk_phase = PH_COUNT;
                    end
                    PH_COUNT:
                    begin
                        w.byte_role = ROLE_COUNT;
                        trk_crc = crc16_modbus_byte(trk_crc, b);
                        trk_len = b;
                        trk_phase = (b == 8'h00) ? PH_CRC1 : PH_DATA;
                    end
                    PH_DATA:
                    begin
                        w.byte_role = ROLE_DATA;
                        trk_crc = crc16_modbus_byte(trk_crc, b);
                        w.data_index = trk_taken;
                        trk_taken = trk_taken + 8'd1;
                        if (trk_taken >= trk_len)
                            trk_phase = PH_CRC1;
                    end
                    PH_CRC1:
                    begin
                        w.byte_role = ROLE_CRC1;
                        trk_first = b;
                        trk_phase = PH_CRC2;
                    end
                    PH_CRC2:
                    begin
                        w.byte_role = ROLE_CRC2;
                        w.frame_done = 1'b1;
                        w.crc_match = ({b, trk_first} == trk_crc);
                        trk_phase = PH_END;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        w.frame_state = trk_phase;
        w.running_crc = trk_crc;
        return w;
    endfunction

    task automatic report_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s expected %h actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            pending_words.push_back(next_frame_word(action, rx_byte));
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_words.size() == 0)
            begin
                $display("%0t ns: output word with none expected, expected none actual %h",
                         $time, byte_value);
                mismatches++;
            end
            else
            begin
                want_word = pending_words.pop_front();
                report_field("frame_state", 16'(want_word.frame_state), 16'(frame_state));
                report_field("byte_role", 16'(want_word.byte_role), 16'(byte_role));
                report_field("byte_value", 16'(want_word.byte_value), 16'(byte_value));
                report_field("data_index", 16'(want_word.data_index), 16'(data_index));
                report_field("address_mismatch", 16'(want_word.address_mismatch),
                             16'(address_mismatch));
                report_field("running_crc", want_word.running_crc, running_crc);
                report_field("frame_done", 16'(want_word.frame_done), 16'(frame_done));
                report_field("crc_match", 16'(want_word.crc_match), 16'(crc_match));
            end
        end
    end

    always @(posedge clk)
        out_stall <= !quiet && ($urandom_range(0, 99) < 7);

    task automatic send_word(input logic [1:0] act, input logic [7:0] b);
        while (!quiet && $urandom_range(0, 99) < 7)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        rx_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
    endtask

    // only while idle: drain all outstanding words first
    task automatic write_address(input logic [7:0] a);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= a;
        @(posedge clk);
        cfg_we <= 1'b0;
        trk_addr = a;
    endtask

    task automatic send_frame(input int force_len);
        logic [15:0] acc;
        logic [7:0]  adr;
        logic [7:0]  cnt;
        logic [7:0]  b;
        int          r;
        acc = CRC_INIT;
        if ($urandom_range(0, 19) == 0)
            send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        send_word(ACT_START, 8'($urandom_range(0, 255)));
        if (force_len >= 0 || $urandom_range(0, 9) != 0)
            adr = trk_addr;
        else
            adr = 8'($urandom_range(0, 255));
        send_word(ACT_BYTE, adr);
        acc = crc16_modbus_byte(acc, adr);
        if (adr != trk_addr)
        begin
            if ($urandom_range(0, 1) == 1)
                send_word(ACT_BYTE, 8'($urandom_range(0, 255)));
            return;
        end
        b = 8'($urandom_range(0, 255));
        send_word(ACT_BYTE, b);
        acc = crc16_modbus_byte(acc, b);
        if (force_len >= 0)
            cnt = 8'(force_len);
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 15)
                cnt = 8'h00;
            else if (r < 95)
                cnt = 8'($urandom_range(1, 8));
            else
                cnt = 8'($urandom_range(9, 40));
        end
        send_word(ACT_BYTE, cnt);
        acc = crc16_modbus_byte(acc, cnt);
        for (int i = 0; i < cnt; i++)
        begin
            if (force_len < 0 && $urandom_range(0, 99) < 2)
            begin
                send_word($urandom_range(0, 1) ? ACT_RELEASE : ACT_START,
                          8'($urandom_range(0, 255)));
                return;
            end
            b = 8'($urandom_range(0, 255));
            send_word(ACT_BYTE, b);
            acc = crc16_modbus_byte(acc, b);
        end
        r = $urandom_range(0, 99);
        if (r < 75)
        begin
            send_word(ACT_BYTE, acc[7:0]);
            send_word(ACT_BYTE, acc[15:8]);
        end
        else if (r < 85)
        begin
            send_word(ACT_BYTE, acc[7:0] ^ (8'h01 << $urandom_range(0, 7)));
            send_word(ACT_BYTE, acc[15:8]);
        end
        else
        begin
            send_word(ACT_BYTE, acc[7:0]);
            send_word(ACT_BYTE, 8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 2) == 0)
            send_word(ACT_BYTE, 8'($urandom_range(0, 255)));
    endtask

    task automatic test_ignored_words();
        send_word(ACT_BYTE, 8'hA5);
        send_word(ACT_UNUSED, 8'hFF);
        send_word(ACT_RELEASE, 8'h00);
    endtask

    // address register still at its reset value
    task automatic test_reset_address();
        send_word(ACT_START, 8'h00);
        send_word(ACT_BYTE, 8'h00);
        send_word(ACT_RELEASE, 8'h5A);
    endtask

    task automatic test_good_frame();
        logic [15:0] acc;
        write_address(8'hFF);
        acc = CRC_INIT;
        acc = crc16_modbus_byte(acc, 8'hFF);
        acc = crc16_modbus_byte(acc, 8'h03);
        acc = crc16_modbus_byte(acc, 8'h02);
        acc = crc16_modbus_byte(acc, 8'h00);
        acc = crc16_modbus_byte(acc, 8'hFF);
        send_word(ACT_START, 8'h00);
        send_word(ACT_BYTE, 8'hFF);
        send_word(ACT_BYTE, 8'h03);
        send_word(ACT_BYTE, 8'h02);
        send_word(ACT_BYTE, 8'h00);
        send_word(ACT_BYTE, 8'hFF);
        send_word(ACT_BYTE, acc[7:0]);
        send_word(ACT_BYTE, acc[15:8]);
        send_word(ACT_BYTE, 8'h77);
    endtask

    task automatic test_zero_count_bad_crc();
        logic [15:0] acc;
        write_address(8'h00);
        acc = CRC_INIT;
        acc = crc16_modbus_byte(acc, 8'h00);
        acc = crc16_modbus_byte(acc, 8'h80);
        acc = crc16_modbus_byte(acc, 8'h00);
        send_word(ACT_START, 8'hFF);
        send_word(ACT_BYTE, 8'h00);
        send_word(ACT_BYTE, 8'h80);
        send_word(ACT_BYTE, 8'h00);
        send_word(ACT_BYTE, acc[7:0]);
        send_word(ACT_BYTE, ~acc[15:8]);
    endtask

    task automatic test_address_mismatch();
        send_word(ACT_START, 8'h00);
        send_word(ACT_BYTE, 8'h01);
        send_word(ACT_BYTE, 8'h55);
    endtask

    task automatic test_random_traffic();
        int base;
        int frames;
        int r;
        base = words_sent;
        frames = 0;
        while (words_sent - base < RAND_WORDS)
        begin
            quiet = (words_sent - base >= 300) && (words_sent - base < 550);
            if (frames % 12 == 11)
            begin
                r = $urandom_range(0, 3);
                if (r == 0)
                    write_address(8'h00);
                else if (r == 1)
                    write_address(8'hFF);
                else
                    write_address(8'($urandom_range(0, 255)));
            end
            if (frames == 20)
                send_frame(255);
            else if (frames == 45)
                send_frame(254);
            else
                send_frame(-1);
            frames++;
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_ignored_words();
        test_reset_address();
        test_good_frame();
        test_zero_count_bad_crc();
        test_address_mismatch();
        test_random_traffic();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

[sim.f]
+incdir+hdl
hdl/mrf_pkg.sv
hdl/mrf_front.sv
hdl/mrf_queue.sv
hdl/mrf_back.sv
hdl/modbus_rtu_response_framer_unit.sv
hdl/mrf_checker.sv
verif/tb_modbus_rtu_response_framer_unit.sv
